// ===== src/aabbcr_pkg.sv =====
// ----------------------------------------------------------------------------
// aabbcr_pkg
// Shared types and codes of the rectangle collision resolver.
// ----------------------------------------------------------------------------
`default_nettype none

package aabbcr_pkg;

    // One stored rectangle: left edge, top edge, width, height (Q15.8).
    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic        [22:0] w;
        logic        [22:0] h;
    } t_rect;

    // Working coordinate, wide enough that no sum inside a step wraps.
    typedef logic signed [26:0] t_coord;

    localparam int COUNT_W  = 7;
    localparam int CFG_IDX_W = 4;

    typedef enum logic [1:0] {
        OP_STEP          = 2'd0,
        OP_LOAD_TERRAIN  = 2'd1,
        OP_LOAD_PLATFORM = 2'd2,
        OP_UNUSED        = 2'd3
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_TERRAIN_COUNT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATFORM_COUNT = 4'd1;

    localparam logic [3:0] HIT_LEFT  = 4'h1;
    localparam logic [3:0] HIT_RIGHT = 4'h2;
    localparam logic [3:0] HIT_UP    = 4'h4;
    localparam logic [3:0] HIT_DOWN  = 4'h8;

endpackage

`default_nettype wire

// ===== src/aabbcr_if.sv =====
// ----------------------------------------------------------------------------
// aabbcr interfaces
// Valid/ready channels for step and load items, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface aabbcr_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [5:0]         table_index;
    logic signed [23:0] rect_x;
    logic signed [23:0] rect_y;
    logic [22:0]        rect_w;
    logic [22:0]        rect_h;
    logic signed [23:0] vel_x;
    logic signed [23:0] vel_y;
    logic               drop_through;

    modport source (
        output valid, op, table_index, rect_x, rect_y, rect_w, rect_h,
               vel_x, vel_y, drop_through,
        input  ready
    );
    modport sink (
        input  valid, op, table_index, rect_x, rect_y, rect_w, rect_h,
               vel_x, vel_y, drop_through,
        output ready
    );
endinterface

interface aabbcr_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
    logic signed [23:0] new_vx;
    logic signed [23:0] new_vy;
    logic [3:0]         hit_mask;

    modport source (
        output valid, new_x, new_y, new_vx, new_vy, hit_mask,
        input  ready
    );
    modport sink (
        input  valid, new_x, new_y, new_vx, new_vy, hit_mask,
        output ready
    );
endinterface

interface aabbcr_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/aabbcr_ram.sv =====
// ----------------------------------------------------------------------------
// aabbcr_ram
// Rectangle table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module aabbcr_ram
    import aabbcr_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_rect         i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_rect              o_rdata
);

    t_rect r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/aabb_collision_resolver_top.sv =====
// ----------------------------------------------------------------------------
// aabb_collision_resolver_top
// Moves a body rectangle along x, then y, clipping against a terrain table,
// and lands it on one-way platforms.
// A step item walks the terrain table for x, then for y, and may then walk the
// platform table, reading one table entry per cycle; a hit ends a walk early,
// and an unread earlier result holds the item in its last state. The next item
// can be accepted once the result is registered. Load items are written on
// acceptance and give no result. Reset clears both count registers and the
// control state; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_collision_resolver_top
    import aabbcr_pkg::*;
#(
    parameter int TERRAIN_DEPTH  = 64,
    parameter int PLATFORM_DEPTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    aabbcr_in_if.sink     i_item,
    aabbcr_cfg_if.sink    i_cfg,
    aabbcr_out_if.source  o_result
);

    localparam int T_AW = (TERRAIN_DEPTH  > 1) ? $clog2(TERRAIN_DEPTH)  : 1;
    localparam int P_AW = (PLATFORM_DEPTH > 1) ? $clog2(PLATFORM_DEPTH) : 1;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_XSCAN = 5'b00010,
        S_YSCAN = 5'b00100,
        S_PSCAN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    function automatic t_coord sx24(input logic signed [23:0] v);
        return t_coord'(v);
    endfunction

    function automatic t_coord ux23(input logic [22:0] v);
        return $signed({4'b0000, v});
    endfunction

    t_state               r_state, n_state;
    logic [COUNT_W-1:0]   r_terrain_count, r_platform_count;
    logic [COUNT_W-1:0]   r_idx, n_idx;
    logic                 r_chk, n_chk;
    t_coord               r_bx, n_bx, r_by, n_by, r_start_bot, n_start_bot;
    logic [22:0]          r_bw, n_bw, r_bh, n_bh;
    logic signed [23:0]   r_vx, n_vx, r_vy, n_vy;
    logic                 r_drop, n_drop;
    logic [3:0]           r_mask, n_mask;

    logic                 r_out_valid;
    logic signed [23:0]   r_out_x, r_out_y, r_out_vx, r_out_vy;
    logic [3:0]           r_out_mask;

    logic                 in_acc, out_free, load_out;
    logic [COUNT_W-1:0]   terrain_live, platform_live, scan_n;
    logic                 ter_we, plat_we, ter_re, plat_re;
    t_rect                load_rect, ter_q, plat_q, ent;
    t_coord               ex, ey, er, eb, br, bb;
    logic                 ovl, hit, scan_end;

    // ---------------------------------------------------------------- tables
    assign load_rect.x = i_item.rect_x;
    assign load_rect.y = i_item.rect_y;
    assign load_rect.w = i_item.rect_w;
    assign load_rect.h = i_item.rect_h;

    assign in_acc  = i_item.valid && i_item.ready;
    assign ter_we  = in_acc && (i_item.op == OP_LOAD_TERRAIN)
                     && (32'(i_item.table_index) < TERRAIN_DEPTH);
    assign plat_we = in_acc && (i_item.op == OP_LOAD_PLATFORM)
                     && (32'(i_item.table_index) < PLATFORM_DEPTH);

    aabbcr_ram #(.DEPTH(TERRAIN_DEPTH), .AW(T_AW)) u_terrain (
        .i_clk   (i_clk),
        .i_we    (ter_we),
        .i_waddr (T_AW'(i_item.table_index)),
        .i_wdata (load_rect),
        .i_re    (ter_re),
        .i_raddr (T_AW'(r_idx)),
        .o_rdata (ter_q)
    );

    aabbcr_ram #(.DEPTH(PLATFORM_DEPTH), .AW(P_AW)) u_platform (
        .i_clk   (i_clk),
        .i_we    (plat_we),
        .i_waddr (P_AW'(i_item.table_index)),
        .i_wdata (load_rect),
        .i_re    (plat_re),
        .i_raddr (P_AW'(r_idx)),
        .o_rdata (plat_q)
    );

    // -------------------------------------------------------- configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terrain_count  <= '0;
            r_platform_count <= '0;
        end else if (i_cfg.valid) begin
            if (i_cfg.index == CFG_TERRAIN_COUNT) begin
                r_terrain_count <= i_cfg.data;
            end else if (i_cfg.index == CFG_PLATFORM_COUNT) begin
                r_platform_count <= i_cfg.data;
            end
        end
    end

    // A count above the table depth walks the whole table.
    assign terrain_live  = (32'(r_terrain_count) > TERRAIN_DEPTH)
                           ? COUNT_W'(TERRAIN_DEPTH) : r_terrain_count;
    assign platform_live = (32'(r_platform_count) > PLATFORM_DEPTH)
                           ? COUNT_W'(PLATFORM_DEPTH) : r_platform_count;

    // -------------------------------------------------------- overlap test
    always_comb begin
        ent = (r_state == S_PSCAN) ? plat_q : ter_q;
        ex  = sx24(ent.x);
        ey  = sx24(ent.y);
        er  = ex + ux23(ent.w);
        eb  = ey + ux23(ent.h);
        br  = r_bx + ux23(r_bw);
        bb  = r_by + ux23(r_bh);
        ovl = (r_bx < er) && (br > ex) && (r_by < eb) && (bb > ey);
        hit = r_chk && ovl && ((r_state != S_PSCAN) || (r_start_bot <= ey));
        scan_n   = (r_state == S_PSCAN) ? platform_live : terrain_live;
        // The walk ends on the first hit or once the last entry was checked.
        scan_end = hit || (r_idx == scan_n);
    end

    // ------------------------------------------------------------ sequencer
    assign i_item.ready = (r_state == S_IDLE);
    assign out_free     = !r_out_valid || o_result.ready;
    assign load_out     = (r_state == S_DONE) && out_free;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_chk       = 1'b0;
        n_bx        = r_bx;
        n_by        = r_by;
        n_bw        = r_bw;
        n_bh        = r_bh;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_start_bot = r_start_bot;
        n_drop      = r_drop;
        n_mask      = r_mask;
        ter_re      = 1'b0;
        plat_re     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_item.op == OP_STEP)) begin
                    n_bx        = sx24(i_item.rect_x) + sx24(i_item.vel_x);
                    n_by        = sx24(i_item.rect_y);
                    n_bw        = i_item.rect_w;
                    n_bh        = i_item.rect_h;
                    n_vx        = i_item.vel_x;
                    n_vy        = i_item.vel_y;
                    n_start_bot = sx24(i_item.rect_y) + ux23(i_item.rect_h);
                    n_drop      = i_item.drop_through;
                    n_mask      = '0;
                    n_idx       = '0;
                    n_state     = S_XSCAN;
                end
            end
            S_XSCAN: begin
                if (scan_end) begin
                    if (hit) begin
                        if ((r_vx > 24'sd0) && (br >= ex)) begin
                            n_vx   = '0;
                            n_bx   = ex - ux23(r_bw);
                            n_mask = r_mask | HIT_RIGHT;
                        end else if ((r_vx < 24'sd0) && (r_bx <= er)) begin
                            n_vx   = '0;
                            n_bx   = er;
                            n_mask = r_mask | HIT_LEFT;
                        end
                    end
                    n_by    = r_by + sx24(r_vy);
                    n_idx   = '0;
                    n_state = S_YSCAN;
                end else begin
                    ter_re = 1'b1;
                    n_chk  = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_YSCAN: begin
                if (scan_end) begin
                    if (hit) begin
                        if ((r_vy > 24'sd0) && (bb >= ey)) begin
                            n_vy   = '0;
                            n_by   = ey - ux23(r_bh);
                            n_mask = r_mask | HIT_DOWN;
                        end else if ((r_vy < 24'sd0) && (r_by <= eb)) begin
                            n_vy   = '0;
                            n_by   = eb;
                            n_mask = r_mask | HIT_UP;
                        end
                    end
                    n_idx = '0;
                    // Platforms only catch a body that is still falling and not dropping through.
                    if ((n_vy > 24'sd0) && !r_drop) begin
                        n_state = S_PSCAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    ter_re = 1'b1;
                    n_chk  = 1'b1;
                    n_idx  = r_idx + 1'b1;
                end
            end
            S_PSCAN: begin
                if (scan_end) begin
                    if (hit) begin
                        n_vy   = '0;
                        n_by   = ey - ux23(r_bh);
                        n_mask = r_mask | HIT_DOWN;
                    end
                    n_state = S_DONE;
                end else begin
                    plat_re = 1'b1;
                    n_chk   = 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_chk   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_chk   <= n_chk;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bx        <= n_bx;
        r_by        <= n_by;
        r_bw        <= n_bw;
        r_bh        <= n_bh;
        r_vx        <= n_vx;
        r_vy        <= n_vy;
        r_start_bot <= n_start_bot;
        r_drop      <= n_drop;
        r_mask      <= n_mask;
    end

    // ------------------------------------------------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_x    <= r_bx[23:0];
            r_out_y    <= r_by[23:0];
            r_out_vx   <= r_vx;
            r_out_vy   <= r_vy;
            r_out_mask <= r_mask;
        end
    end

    assign o_result.valid    = r_out_valid;
    assign o_result.new_x    = r_out_x;
    assign o_result.new_y    = r_out_y;
    assign o_result.new_vx   = r_out_vx;
    assign o_result.new_vy   = r_out_vy;
    assign o_result.hit_mask = r_out_mask;

endmodule

`default_nettype wire

// ===== test/aabb_collision_resolver_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_collision_resolver_top_test
// Self-checking bench for the rectangle collision resolver. A directed list of
// loads, register writes and steps runs first. Random phases follow: they grow
// both rectangle tables, change the live counts and move bodies through a
// small scene. Each result is checked field by field against a behavioral
// model of the block, or against the result given with a directed step.
// ----------------------------------------------------------------------------
module aabb_collision_resolver_top_test;
    import aabbcr_pkg::*;

    localparam int DEPTH       = 64;
    localparam int COUNT_MAX   = (1 << COUNT_W) - 1;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 110;
    localparam int REG_PAUSE   = 8;
    localparam int END_PAUSE   = 250;
    localparam int QUIET_LIMIT = 4000;
    localparam int MAX_PRINTS  = 40;
    localparam int SCENE       = 'h6000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'hF;

    typedef struct {
        t_op                op;
        logic [5:0]         idx;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic [22:0]        w;
        logic [22:0]        h;
        logic signed [23:0] vx;
        logic signed [23:0] vy;
        logic               drop;
    } t_cmd;

    typedef struct {
        logic signed [23:0] nx;
        logic signed [23:0] ny;
        logic signed [23:0] nvx;
        logic signed [23:0] nvy;
        logic [3:0]         mask;
    } t_move;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [COUNT_W-1:0]   reg_val;
        t_cmd                 cmd;
        bit                   typed;
        t_move                want;
    } t_row;

    logic clk = 1'b0;
    logic rst_n;

    aabbcr_in_if  item_if ();
    aabbcr_cfg_if cfg_if ();
    aabbcr_out_if res_if ();

    aabb_collision_resolver_top DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Behavioral copy of the block state.
    t_rect              terrain_tbl  [DEPTH];
    t_rect              platform_tbl [DEPTH];
    logic [COUNT_W-1:0] terrain_live;
    logic [COUNT_W-1:0] platform_live;
    logic [DEPTH-1:0]   terrain_loaded;
    logic [DEPTH-1:0]   platform_loaded;

    t_move expected_moves [$];
    int    mismatches   = 0;
    int    send_calm    = 0;
    int    ready_calm   = 0;
    int    quiet_cycles = 0;

    function automatic bit boxes_overlap(longint ax, longint ay, longint aw, longint ah,
                                         t_rect b);
        longint bx;
        longint by;
        bx = $signed(b.x);
        by = $signed(b.y);
        return ax < bx + longint'(b.w) && ax + aw > bx &&
               ay < by + longint'(b.h) && ay + ah > by;
    endfunction

    function automatic int live(logic [COUNT_W-1:0] c);
        return (c > DEPTH) ? DEPTH : int'(c);
    endfunction

    // Applies one item to the state; returns 1 when the item gives a result.
    function automatic bit resolve_move(t_cmd c, output t_move m);
        longint     bx, by, bw, bh, vx, vy, start_bottom;
        logic [3:0] mask;
        t_rect      t;
        int         i;
        m = '{default: '0};
        if (c.op == OP_LOAD_TERRAIN) begin
            terrain_tbl[c.idx] = {c.x, c.y, c.w, c.h};
            terrain_loaded[c.idx] = 1'b1;
            return 1'b0;
        end
        if (c.op == OP_LOAD_PLATFORM) begin
            platform_tbl[c.idx] = {c.x, c.y, c.w, c.h};
            platform_loaded[c.idx] = 1'b1;
            return 1'b0;
        end
        if (c.op != OP_STEP) return 1'b0;

        bx = $signed(c.x);
        by = $signed(c.y);
        bw = c.w;
        bh = c.h;
        vx = $signed(c.vx);
        vy = $signed(c.vy);
        mask = '0;
        start_bottom = by + bh;

        // Only the first overlapping terrain entry matters on each axis.
        bx += vx;
        for (i = 0; i < live(terrain_live); i++) begin
            t = terrain_tbl[i];
            if (boxes_overlap(bx, by, bw, bh, t)) begin
                if (vx > 0 && bx + bw >= $signed(t.x)) begin
                    vx = 0;
                    bx = $signed(t.x) - bw;
                    mask |= HIT_RIGHT;
                end else if (vx < 0 && bx <= $signed(t.x) + longint'(t.w)) begin
                    vx = 0;
                    bx = $signed(t.x) + longint'(t.w);
                    mask |= HIT_LEFT;
                end
                break;
            end
        end

        by += vy;
        for (i = 0; i < live(terrain_live); i++) begin
            t = terrain_tbl[i];
            if (boxes_overlap(bx, by, bw, bh, t)) begin
                if (vy > 0 && by + bh >= $signed(t.y)) begin
                    vy = 0;
                    by = $signed(t.y) - bh;
                    mask |= HIT_DOWN;
                end else if (vy < 0 && by <= $signed(t.y) + longint'(t.h)) begin
                    vy = 0;
                    by = $signed(t.y) + longint'(t.h);
                    mask |= HIT_UP;
                end
                break;
            end
        end

        // A platform only catches a body whose bottom started above its top.
        if (vy > 0 && !c.drop) begin
            for (i = 0; i < live(platform_live); i++) begin
                t = platform_tbl[i];
                if (boxes_overlap(bx, by, bw, bh, t) && start_bottom <= $signed(t.y)) begin
                    vy = 0;
                    by = $signed(t.y) - bh;
                    mask |= HIT_DOWN;
                    break;
                end
            end
        end

        m.nx   = bx[23:0];
        m.ny   = by[23:0];
        m.nvx  = vx[23:0];
        m.nvy  = vy[23:0];
        m.mask = mask;
        return 1'b1;
    endfunction

    function automatic int ones_prefix(logic [DEPTH-1:0] v);
        int n;
        n = 0;
        while (n < DEPTH && v[n]) n++;
        return n;
    endfunction

    // Mostly short gaps, some long ones, and now and then a stretch with none.
    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(20, 120);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Half the values land on whole units so that edges meet exactly.
    function automatic int scene_val(int lo, int hi);
        int v;
        v = int'($urandom_range(0, hi - lo)) + lo;
        if ($urandom_range(0, 1) == 1) v = v & ~32'hFF;
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count(int prefix);
        case ($urandom_range(0, 3))
            0: return '0;
            1: return COUNT_W'($urandom_range(0, prefix));
            2: return COUNT_W'(prefix);
            default: return (prefix == DEPTH) ? COUNT_W'($urandom_range(DEPTH, COUNT_MAX))
                                              : COUNT_W'(prefix);
        endcase
    endfunction

    function automatic t_cmd random_cmd();
        t_cmd c;
        int   r;
        int   prefix;
        r = $urandom_range(0, 99);
        c.op   = OP_STEP;
        c.idx  = 6'($urandom);
        c.x    = 24'($urandom);
        c.y    = 24'($urandom);
        c.w    = 23'($urandom);
        c.h    = 23'($urandom);
        c.vx   = 24'($urandom);
        c.vy   = 24'($urandom);
        c.drop = 1'($urandom);
        if (r < 3) begin
            c.op = OP_UNUSED;
            return c;
        end
        if (r < 25) begin
            if (r < 14) begin
                c.op = OP_LOAD_TERRAIN;
                prefix = ones_prefix(terrain_loaded);
            end else begin
                c.op = OP_LOAD_PLATFORM;
                prefix = ones_prefix(platform_loaded);
            end
            // Mostly extend the loaded run so larger counts become legal.
            if (prefix < DEPTH && $urandom_range(0, 7) != 0) c.idx = 6'(prefix);
            if ($urandom_range(0, 9) != 0) begin
                c.x = 24'(scene_val(-SCENE, SCENE));
                c.y = 24'(scene_val(-SCENE, SCENE));
                c.w = 23'(scene_val(0, 'h3000));
                c.h = (c.op == OP_LOAD_TERRAIN) ? 23'(scene_val(0, 'h3000))
                                                : 23'(scene_val(0, 'h200));
            end
            return c;
        end
        if (r < 35) return c;
        c.x    = 24'(scene_val(-SCENE, SCENE));
        c.y    = 24'(scene_val(-SCENE, SCENE));
        c.w    = 23'(scene_val('h40, 'h1800));
        c.h    = 23'(scene_val('h40, 'h1800));
        c.vx   = 24'(scene_val(-'h1800, 'h1800));
        c.vy   = ($urandom_range(0, 9) < 6) ? 24'(scene_val(0, 'h1800))
                                            : 24'(scene_val(-'h1800, 'h1800));
        c.drop = ($urandom_range(0, 3) == 0);
        return c;
    endfunction

    function automatic t_row item_row(t_op op, int idx, int x, int y, int w, int h,
                                      int vx, int vy, bit drop);
        t_row r;
        r.is_reg   = 1'b0;
        r.reg_idx  = '0;
        r.reg_val  = '0;
        r.typed    = 1'b0;
        r.want     = '{default: '0};
        r.cmd.op   = op;
        r.cmd.idx  = 6'(idx);
        r.cmd.x    = 24'(x);
        r.cmd.y    = 24'(y);
        r.cmd.w    = 23'(w);
        r.cmd.h    = 23'(h);
        r.cmd.vx   = 24'(vx);
        r.cmd.vy   = 24'(vy);
        r.cmd.drop = drop;
        return r;
    endfunction

    function automatic t_row reg_row(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
        t_row r;
        r = item_row(OP_STEP, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row with_result(t_row r, int nx, int ny, int nvx, int nvy,
                                         logic [3:0] mask);
        r.typed     = 1'b1;
        r.want.nx   = 24'(nx);
        r.want.ny   = 24'(ny);
        r.want.nvx  = 24'(nvx);
        r.want.nvy  = 24'(nvy);
        r.want.mask = mask;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [23:0] got, logic [23:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch in %s: got %06h, expected %06h", what, got, want);
    endtask

    task automatic send_item(t_cmd c, bit typed, t_move want);
        t_move m;
        int    gap;
        item_if.valid        <= 1'b1;
        item_if.op           <= c.op;
        item_if.table_index  <= c.idx;
        item_if.rect_x       <= c.x;
        item_if.rect_y       <= c.y;
        item_if.rect_w       <= c.w;
        item_if.rect_h       <= c.h;
        item_if.vel_x        <= c.vx;
        item_if.vel_y        <= c.vy;
        item_if.drop_through <= c.drop;
        @(posedge clk);
        while (item_if.ready !== 1'b1) @(posedge clk);
        if (resolve_move(c, m)) expected_moves.push_back(typed ? want : m);
        gap = idle_len(send_calm);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle(int pause);
        item_if.valid <= 1'b0;
        while (expected_moves.size() != 0) @(posedge clk);
        repeat (pause) @(posedge clk);
    endtask

    // Leaves the write valid high; the caller lowers it after its last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        if (idx == CFG_TERRAIN_COUNT) terrain_live = val;
        else if (idx == CFG_PLATFORM_COUNT) platform_live = val;
    endtask

    task automatic set_counts(logic [COUNT_W-1:0] tc, logic [COUNT_W-1:0] pc);
        wait_idle(REG_PAUSE);
        write_reg(CFG_TERRAIN_COUNT, tc);
        write_reg(CFG_PLATFORM_COUNT, pc);
        if ($urandom_range(0, 1) == 1)
            write_reg(CFG_IDX_W'($urandom_range(CFG_PLATFORM_COUNT + 1, CFG_UNMAPPED)),
                      COUNT_W'($urandom));
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                hold = idle_len(ready_calm);
            end
        end
    end

    always @(posedge clk) begin : result_check
        t_move want;
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_moves.size() == 0) begin
                report_mismatch("result with none pending", res_if.new_x, '0);
            end else begin
                want = expected_moves.pop_front();
                if (res_if.new_x !== want.nx) report_mismatch("new_x", res_if.new_x, want.nx);
                if (res_if.new_y !== want.ny) report_mismatch("new_y", res_if.new_y, want.ny);
                if (res_if.new_vx !== want.nvx)
                    report_mismatch("new_vx", res_if.new_vx, want.nvx);
                if (res_if.new_vy !== want.nvy)
                    report_mismatch("new_vy", res_if.new_vy, want.nvy);
                if (res_if.hit_mask !== want.mask)
                    report_mismatch("hit_mask", 24'(res_if.hit_mask), 24'(want.mask));
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        t_row               plan [$];
        t_cmd               c;
        t_move              no_move;
        logic [COUNT_W-1:0] tc, pc;
        int                 p, n;
        bit                 reg_open;

        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.op           = OP_STEP;
        item_if.table_index  = '0;
        item_if.rect_x       = '0;
        item_if.rect_y       = '0;
        item_if.rect_w       = '0;
        item_if.rect_h       = '0;
        item_if.vel_x        = '0;
        item_if.vel_y        = '0;
        item_if.drop_through = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        no_move              = '{default: '0};
        terrain_live         = '0;
        platform_live        = '0;
        terrain_loaded       = '0;
        platform_loaded      = '0;

        // Both counts are zero after reset, so a body moves freely and wraps.
        plan.push_back(with_result(item_row(OP_STEP, 0, 'h100, 'h200, 'h100, 'h100,
                                            'h300, -'h80, 1'b0),
                                   'h400, 'h180, 'h300, -'h80, '0));
        plan.push_back(with_result(item_row(OP_STEP, 0, 'h7FFFFF, -'h800000, 'h7FFFFF,
                                            'h7FFFFF, 1, -1, 1'b1),
                                   -'h800000, 'h7FFFFF, 1, -1, '0));
        plan.push_back(with_result(item_row(OP_STEP, 0, -'h800000, 'h7FFFFF, 0, 0,
                                            -'h800000, 'h7FFFFF, 1'b0),
                                   0, -2, -'h800000, 'h7FFFFF, '0));
        plan.push_back(item_row(OP_UNUSED, 63, -1, -1, 'h7FFFFF, 'h7FFFFF, -1, -1, 1'b1));
        // Scene: floor, wall, ceiling and one platform.
        plan.push_back(item_row(OP_LOAD_TERRAIN, 0, 0, 'h6400, 'hC800, 'h0A00, 0, 0, 1'b0));
        plan.push_back(item_row(OP_LOAD_TERRAIN, 1, 'h9600, 0, 'h0A00, 'h6400, 0, 0, 1'b0));
        plan.push_back(item_row(OP_LOAD_TERRAIN, 2, 0, -'h0A00, 'hC800, 'h0A00, 0, 0, 1'b0));
        plan.push_back(item_row(OP_LOAD_PLATFORM, 0, 'h1400, 'h3200, 'h2800, 'h0100,
                                0, 0, 1'b0));
        plan.push_back(item_row(OP_LOAD_TERRAIN, 63, -'h800000, -'h800000, 'h7FFFFF,
                                'h7FFFFF, 0, 0, 1'b0));
        plan.push_back(item_row(OP_LOAD_PLATFORM, 63, 'h7FFF00, 'h7FFF00, 0, 0, 0, 0, 1'b0));
        plan.push_back(reg_row(CFG_TERRAIN_COUNT, 3));
        plan.push_back(reg_row(CFG_PLATFORM_COUNT, 1));
        plan.push_back(reg_row(CFG_UNMAPPED, COUNT_W'(COUNT_MAX)));
        plan.push_back(item_row(OP_STEP, 0, 'h0A00, 'h5000, 'h0A00, 'h0A00, 0, 'h1400, 1'b0));
        plan.push_back(item_row(OP_STEP, 0, 'h8C00, 'h1E00, 'h0A00, 'h0A00, 'h0500, 0, 1'b0));
        plan.push_back(item_row(OP_STEP, 0, 'hA500, 'h1E00, 'h0A00, 'h0A00, -'h0A00, 0, 1'b0));
        plan.push_back(item_row(OP_STEP, 0, 'h3200, 'h0500, 'h0A00, 'h0A00, 0, -'h0A00, 1'b0));
        plan.push_back(item_row(OP_STEP, 0, 'h1E00, 'h2300, 'h0A00, 'h0A00, 0, 'h0A00, 1'b0));
        plan.push_back(item_row(OP_STEP, 0, 'h1E00, 'h2300, 'h0A00, 'h0A00, 0, 'h0A00, 1'b1));
        // Bottom already below the platform top: the body falls on through.
        plan.push_back(item_row(OP_STEP, 0, 'h1E00, 'h2E00, 'h0A00, 'h0A00, 0, 'h0100, 1'b0));
        // Edges that only touch do not overlap; then a body at rest inside the wall and one moving into it.
        plan.push_back(item_row(OP_STEP, 0, 'h8C00, 'h1E00, 'h0A00, 'h0A00, 0, 0, 1'b0));
        plan.push_back(item_row(OP_STEP, 0, 'h9800, 'h1E00, 'h0100, 'h0100, 0, 0, 1'b0));
        plan.push_back(item_row(OP_STEP, 0, 'h8C00, 'h5500, 'h0A00, 'h0A00, 'h0800, 'h0800,
                                1'b0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        reg_open = 1'b0;
        foreach (plan[r]) begin
            if (plan[r].is_reg) begin
                if (!reg_open) begin
                    wait_idle(REG_PAUSE);
                    reg_open = 1'b1;
                end
                write_reg(plan[r].reg_idx, plan[r].reg_val);
            end else begin
                if (reg_open) begin
                    cfg_if.valid <= 1'b0;
                    reg_open = 1'b0;
                end
                send_item(plan[r].cmd, plan[r].typed, plan[r].want);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            if (p == PHASES - 2) begin
                // Fill both tables so the full and oversized counts are legal.
                while (!(&terrain_loaded) || !(&platform_loaded)) begin
                    c = random_cmd();
                    if (c.op == OP_LOAD_TERRAIN || c.op == OP_LOAD_PLATFORM)
                        send_item(c, 1'b0, no_move);
                end
                tc = COUNT_W'(DEPTH);
                pc = COUNT_W'(DEPTH);
            end else if (p == PHASES - 1) begin
                tc = COUNT_W'(COUNT_MAX);
                pc = COUNT_W'(COUNT_MAX);
            end else begin
                tc = pick_count(ones_prefix(terrain_loaded));
                pc = pick_count(ones_prefix(platform_loaded));
            end
            set_counts(tc, pc);
            n = 0;
            while (n < PHASE_ITEMS) begin
                c = random_cmd();
                if ($urandom_range(0, 99) == 0) wait_idle(0);
                send_item(c, 1'b0, no_move);
                if (c.op != OP_UNUSED) n++;
            end
        end

        wait_idle(END_PAUSE);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== aabb_collision_resolver_top.f =====
src/aabbcr_pkg.sv
src/aabbcr_if.sv
src/aabbcr_ram.sv
src/aabb_collision_resolver_top.sv
test/aabb_collision_resolver_top_test.sv
